// File: src/lect_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lect_pkg
// Shared types, constants and helpers for the lane edge and center tracker.
// ---------------------------------------------------------------------------
package lect_pkg;

    localparam int IMAGE_COLUMNS = 80;
    localparam int HALF_COLUMNS  = 40;
    localparam int COL_W         = 7;
    localparam int ROW_W         = 5;
    localparam int ROW_DEPTH     = 32;
    localparam int SUM_W         = 12;
    localparam int DIV_STEPS     = SUM_W;
    localparam int CNT_W         = 4;
    localparam int DIVR_W        = 5;

    localparam logic [ROW_W-1:0] NEAR_ROW = 5'd29;
    localparam logic [ROW_W-1:0] FAR_ROW  = 5'd2;
    localparam logic [ROW_W-1:0] SCAN_TOP = 5'd30;

    localparam logic [COL_W-1:0] COL_LAST   = 7'd79;
    localparam logic [COL_W-1:0] COL_CENTER = 7'd40;
    localparam logic [7:0]       STEP_LIMIT = 8'd10;
    localparam logic [7:0]       RING_GAP   = 8'd40;
    localparam logic [7:0]       ZEBRA_MAX  = 8'd20;
    localparam logic [7:0]       ZEBRA_MIN  = 8'd3;

    localparam logic [2:0] CFG_RING_RIGHT   = 3'd0;
    localparam logic [2:0] CFG_RING_EXIT    = 3'd1;
    localparam logic [2:0] CFG_RING_INSIDE  = 3'd2;
    localparam logic [2:0] CFG_RING_ENTERED = 3'd3;
    localparam logic [2:0] CFG_STOP_DETECT  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_CALC,
        ST_CHECK,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic load_in;
        logic find;
        logic calc;
        logic div_init;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_row;
        logic div_empty;
        logic out_free;
    } ctrl_sts_t;

    // highest black column at or below from, bit 7 = found
    function automatic logic [7:0] find_down(input logic [IMAGE_COLUMNS-1:0] v,
                                             input logic [COL_W-1:0] from);
        logic [7:0] res;
        res = '0;
        for (int i = 0; i < IMAGE_COLUMNS; i++) begin
            if (v[i] && (COL_W'(i) <= from)) begin
                res = {1'b1, COL_W'(i)};
            end
        end
        return res;
    endfunction

    // lowest black column at or above from, bit 7 = found
    function automatic logic [7:0] find_up(input logic [IMAGE_COLUMNS-1:0] v,
                                           input logic [COL_W-1:0] from);
        logic [7:0] res;
        res = '0;
        for (int i = IMAGE_COLUMNS - 1; i >= 0; i--) begin
            if (v[i] && (COL_W'(i) >= from)) begin
                res = {1'b1, COL_W'(i)};
            end
        end
        return res;
    endfunction

    function automatic logic signed [10:0] sx8(input logic signed [10:0] x);
        return {{3{x[7]}}, x[7:0]};
    endfunction

    function automatic logic signed [10:0] u8(input logic signed [10:0] x);
        return {3'b000, x[7:0]};
    endfunction

endpackage

// File: src/lect_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lect_ctrl
// Row sequencer: edge search, row update, frame mean divide, result load.
// ---------------------------------------------------------------------------
module lect_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lect_pkg::ctrl_sts_t  sts,
    output lect_pkg::ctrl_cmd_t  cmd
);

    lect_pkg::state_t state_reg, state_next;
    logic [lect_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lect_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            lect_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = lect_pkg::ST_FIND;
                end
            end
            lect_pkg::ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = lect_pkg::ST_CALC;
            end
            lect_pkg::ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = lect_pkg::ST_CHECK;
            end
            lect_pkg::ST_CHECK: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                if (sts.frame_row && !sts.div_empty) begin
                    state_next = lect_pkg::ST_DIV;
                end else begin
                    state_next = lect_pkg::ST_LOAD;
                end
            end
            lect_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == lect_pkg::CNT_W'(lect_pkg::DIV_STEPS - 1)) begin
                    state_next = lect_pkg::ST_LOAD;
                end
            end
            lect_pkg::ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = lect_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lect_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/lect_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lect_datapath
// Edge search, edge substitution and limiting, tracking state, serial divider
// and the result register.
// ---------------------------------------------------------------------------
module lect_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lect_pkg::ctrl_cmd_t  cmd,
    output lect_pkg::ctrl_sts_t  sts,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic                 cfg_data,
    input  logic [4:0]           s_row_index,
    input  logic [39:0]          s_pixels_left,
    input  logic [39:0]          s_pixels_right,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [4:0]           m_row_number,
    output logic                 m_row_used,
    output logic signed [7:0]    m_left_edge,
    output logic [7:0]           m_right_edge,
    output logic [6:0]           m_center,
    output logic [7:0]           m_lane_width,
    output logic [1:0]           m_edge_status,
    output logic                 m_frame_done,
    output logic signed [8:0]    m_steering,
    output logic                 m_stop_request
);

    localparam int CW = lect_pkg::COL_W;
    localparam int RW = lect_pkg::ROW_W;

    // configuration
    logic ring_right_reg, ring_exit_reg, ring_inside_reg, ring_entered_reg, stop_detect_reg;

    // latched row
    logic [RW-1:0] row_reg;
    logic [lect_pkg::IMAGE_COLUMNS-1:0] pix_reg;

    // search results
    logic          lf_reg, rf_reg, pc_black_reg;
    logic [CW-1:0] lpos_reg, rpos_reg;

    // tracking state
    logic [CW-1:0] base_column_reg, base_column_next;
    logic [7:0]    rr0_reg, rr1_reg;
    logic [7:0]    lh0_reg, lh0_next, lh1_reg, lh1_next;
    logic [7:0]    rh0_reg, rh0_next, rh1_reg, rh1_next;
    logic [CW-1:0] prev_center_reg, prev_center_next;
    logic [CW-1:0] bottom_reg, bottom_next;
    logic [lect_pkg::SUM_W-1:0] center_sum_reg, center_sum_next;
    logic [RW-1:0] stop_row_reg, stop_row_next;
    logic          scan_ended_reg, scan_ended_next;
    logic [7:0]    near_width_reg, near_width_next;
    logic [7:0]    store_l_reg [lect_pkg::ROW_DEPTH];
    logic [7:0]    store_r_reg [lect_pkg::ROW_DEPTH];
    logic          push;

    // row result before frame fields
    logic          res_used_reg, res_used_next;
    logic [7:0]    res_l_reg, res_l_next, res_r_reg, res_r_next;
    logic [CW-1:0] res_mid_reg, res_mid_next;
    logic [1:0]    res_status_reg, res_status_next;

    // divider
    logic [lect_pkg::SUM_W-1:0]  quo_reg;
    logic [lect_pkg::DIVR_W-1:0] rem_reg, divisor_reg;
    logic [lect_pkg::DIVR_W:0]   trial;

    logic          frame_row, div_empty;
    logic signed [9:0] extrap;

    logic [lect_pkg::IMAGE_COLUMNS-1:0] in_vec;
    logic [CW-1:0] from_col;
    logic [7:0]    fl, fr;

    assign in_vec = {s_pixels_right, s_pixels_left};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_right_reg   <= 1'b0;
            ring_exit_reg    <= 1'b0;
            ring_inside_reg  <= 1'b0;
            ring_entered_reg <= 1'b0;
            stop_detect_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                lect_pkg::CFG_RING_RIGHT:   ring_right_reg   <= cfg_data;
                lect_pkg::CFG_RING_EXIT:    ring_exit_reg    <= cfg_data;
                lect_pkg::CFG_RING_INSIDE:  ring_inside_reg  <= cfg_data;
                lect_pkg::CFG_RING_ENTERED: ring_entered_reg <= cfg_data;
                lect_pkg::CFG_STOP_DETECT:  stop_detect_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            row_reg <= s_row_index;
            pix_reg <= in_vec;
        end
    end

    // edge search, from the base column on base rows, else the last center
    assign from_col = (row_reg > lect_pkg::NEAR_ROW) ? base_column_reg : prev_center_reg;
    assign fl = lect_pkg::find_down(pix_reg, from_col);
    assign fr = lect_pkg::find_up(pix_reg, from_col);

    always_ff @(posedge aclk) begin
        if (cmd.find) begin
            lf_reg       <= fl[7];
            rf_reg       <= fr[7];
            lpos_reg     <= fl[CW-1:0];
            rpos_reg     <= fr[CW-1:0];
            pc_black_reg <= pix_reg[prev_center_reg];
        end
    end

    always_comb begin
        logic signed [10:0] l, r, l1, l2, r1, r2, mid, pcs, s, lp, rp, lim;
        logic scan;
        base_column_next = base_column_reg;
        lh0_next         = lh0_reg;
        lh1_next         = lh1_reg;
        rh0_next         = rh0_reg;
        rh1_next         = rh1_reg;
        prev_center_next = prev_center_reg;
        bottom_next      = bottom_reg;
        center_sum_next  = center_sum_reg;
        stop_row_next    = stop_row_reg;
        scan_ended_next  = scan_ended_reg;
        near_width_next  = near_width_reg;
        push             = 1'b0;
        res_used_next    = 1'b0;
        res_l_next       = '0;
        res_r_next       = '0;
        res_mid_next     = '0;
        res_status_next  = {~rf_reg, ~lf_reg};
        lp  = {4'b0000, lpos_reg};
        rp  = {4'b0000, rpos_reg};
        l1  = {{3{lh0_reg[7]}}, lh0_reg};
        l2  = {{3{lh1_reg[7]}}, lh1_reg};
        r1  = {3'b000, rh0_reg};
        r2  = {3'b000, rh1_reg};
        pcs = {4'b0000, prev_center_reg};
        lim = {3'b000, lect_pkg::STEP_LIMIT};
        l   = '0;
        r   = '0;
        mid = '0;
        s   = '0;
        scan = (row_reg <= lect_pkg::NEAR_ROW) && (row_reg >= lect_pkg::FAR_ROW)
            && !scan_ended_reg;

        if (row_reg > lect_pkg::NEAR_ROW) begin
            if (lf_reg && rf_reg) begin
                l = lp;
                r = rp;
            end else if (!lf_reg && !rf_reg) begin
                l = '0;
                r = {4'b0000, lect_pkg::COL_LAST};
            end else if (!lf_reg) begin
                l = '0;
                r = rp;
            end else begin
                l = lp;
                r = {4'b0000, lect_pkg::COL_LAST};
            end
            if (!lf_reg && !rf_reg) begin
                mid = {4'b0000, base_column_reg};
            end else begin
                mid = (l + r) >>> 1;
            end
            if (row_reg == lect_pkg::SCAN_TOP) begin
                mid = (mid + {4'b0000, bottom_reg}) >>> 1;
                base_column_next = mid[CW-1:0];
                prev_center_next = mid[CW-1:0];
                center_sum_next  = '0;
                scan_ended_next  = 1'b0;
                stop_row_next    = lect_pkg::FAR_ROW;
            end else begin
                bottom_next = mid[CW-1:0];
            end
            push          = 1'b1;
            res_used_next = 1'b1;
        end else if (scan) begin
            if (pc_black_reg) begin
                stop_row_next   = row_reg + 1'b1;
                scan_ended_next = 1'b1;
            end else begin
                l = lf_reg ? lp : {{3{store_l_reg[row_reg][7]}}, store_l_reg[row_reg]};
                r = rf_reg ? rp : {3'b000, store_r_reg[row_reg]};
                if (!lf_reg && !rf_reg) begin
                    if (!ring_right_reg) begin
                        l = lect_pkg::sx8((l1 <<< 1) - l2);
                        r = lect_pkg::u8((r1 <<< 1) - r2);
                    end else if (!ring_inside_reg) begin
                        r = lect_pkg::u8(r1 + 11'sd1);
                        l = lect_pkg::sx8(l1 + 11'sd1);
                    end
                end else if (!lf_reg) begin
                    if (r > r1) begin
                        l = lect_pkg::sx8(l1 + r1 - r);
                        r = lect_pkg::u8((r1 <<< 1) - r);
                    end else begin
                        l = lect_pkg::sx8(l1 + r - r1);
                    end
                end else if (!rf_reg) begin
                    if (l < l1) begin
                        r = lect_pkg::u8(r1 + l1 - l);
                        l = lect_pkg::sx8((l1 <<< 1) - l);
                    end else begin
                        r = lect_pkg::u8(r1 + l - l1);
                    end
                end
                if (ring_exit_reg && ring_right_reg) begin
                    r = lect_pkg::u8(l + {3'b000, lect_pkg::RING_GAP});
                end
                // step limits compare signed differences
                if (r - r1 > lim) begin
                    r = lect_pkg::u8(r1 + lim);
                end else if (r - r1 < -lim) begin
                    r = lect_pkg::u8(r1 - lim);
                end
                if (l - l1 > lim) begin
                    l = lect_pkg::sx8(l1 + lim);
                end else if (l - l1 < -lim) begin
                    l = lect_pkg::sx8(l1 - lim);
                end
                // halve toward zero
                s   = l + r;
                mid = s >>> 1;
                if (s[10] && s[0]) begin
                    mid = mid + 11'sd1;
                end
                mid = lect_pkg::sx8(mid);
                if (mid - pcs > 11'sd3) begin
                    mid = pcs + 11'sd2;
                end
                if (mid - pcs < -11'sd3) begin
                    mid = pcs - 11'sd2;
                end
                if (mid < 0) begin
                    mid = '0;
                end else if (mid > {4'b0000, lect_pkg::COL_LAST}) begin
                    mid = {4'b0000, lect_pkg::COL_LAST};
                end
                center_sum_next = center_sum_reg + {5'b00000, mid[CW-1:0]};
                if (row_reg == lect_pkg::NEAR_ROW) begin
                    near_width_next = 8'(r - l);
                end
                if (row_reg == lect_pkg::FAR_ROW) begin
                    stop_row_next = lect_pkg::FAR_ROW;
                end
                prev_center_next = mid[CW-1:0];
                push             = 1'b1;
                res_used_next    = 1'b1;
            end
        end

        if (push) begin
            lh1_next = lh0_reg;
            lh0_next = l[7:0];
            rh1_next = rh0_reg;
            rh0_next = r[7:0];
        end
        if (res_used_next) begin
            res_l_next   = l[7:0];
            res_r_next   = r[7:0];
            res_mid_next = mid[CW-1:0];
        end else begin
            res_status_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_column_reg <= lect_pkg::COL_CENTER;
            lh0_reg         <= '0;
            lh1_reg         <= '0;
            rh0_reg         <= '0;
            rh1_reg         <= '0;
            prev_center_reg <= '0;
            bottom_reg      <= '0;
            center_sum_reg  <= '0;
            stop_row_reg    <= lect_pkg::FAR_ROW;
            scan_ended_reg  <= 1'b0;
            near_width_reg  <= '0;
            for (int i = 0; i < lect_pkg::ROW_DEPTH; i++) begin
                store_l_reg[i] <= '0;
                store_r_reg[i] <= '0;
            end
        end else if (cmd.calc) begin
            base_column_reg <= base_column_next;
            lh0_reg         <= lh0_next;
            lh1_reg         <= lh1_next;
            rh0_reg         <= rh0_next;
            rh1_reg         <= rh1_next;
            prev_center_reg <= prev_center_next;
            bottom_reg      <= bottom_next;
            center_sum_reg  <= center_sum_next;
            stop_row_reg    <= stop_row_next;
            scan_ended_reg  <= scan_ended_next;
            near_width_reg  <= near_width_next;
            if (push) begin
                store_l_reg[row_reg] <= lh0_next;
                store_r_reg[row_reg] <= rh0_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            res_used_reg   <= res_used_next;
            res_l_reg      <= res_l_next;
            res_r_reg      <= res_r_next;
            res_mid_reg    <= res_mid_next;
            res_status_reg <= res_status_next;
        end
    end

    // frame mean: restoring divide, one quotient bit a cycle
    assign frame_row = (row_reg == lect_pkg::FAR_ROW);
    assign div_empty = (center_sum_reg == '0) || (stop_row_reg > lect_pkg::NEAR_ROW);
    assign trial     = {rem_reg, quo_reg[lect_pkg::SUM_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            quo_reg     <= center_sum_reg;
            rem_reg     <= '0;
            divisor_reg <= lect_pkg::DIVR_W'(lect_pkg::SCAN_TOP - stop_row_reg);
        end else if (cmd.div_step) begin
            if (trial >= {1'b0, divisor_reg}) begin
                rem_reg <= lect_pkg::DIVR_W'(trial - {1'b0, divisor_reg});
                quo_reg <= {quo_reg[lect_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[lect_pkg::DIVR_W-1:0];
                quo_reg <= {quo_reg[lect_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    assign extrap = ({{2{rr0_reg[7]}}, rr0_reg} <<< 1) - {{2{rr1_reg[7]}}, rr1_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rr0_reg <= 8'(lect_pkg::COL_CENTER);
            rr1_reg <= 8'(lect_pkg::COL_CENTER);
        end else if (cmd.load_out && frame_row && !div_empty) begin
            rr1_reg <= rr0_reg;
            rr0_reg <= quo_reg[7:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_row_number  <= row_reg;
            m_row_used    <= res_used_reg;
            m_left_edge   <= res_l_reg;
            m_right_edge  <= res_r_reg;
            m_center      <= res_mid_reg;
            m_lane_width  <= res_r_reg - res_l_reg;
            m_edge_status <= res_status_reg;
            m_frame_done  <= frame_row;
            if (!frame_row) begin
                m_steering <= '0;
            end else if (div_empty) begin
                m_steering <= extrap[8:0];
            end else begin
                m_steering <= quo_reg[8:0];
            end
            m_stop_request <= frame_row && stop_detect_reg && !ring_entered_reg
                && (near_width_reg > lect_pkg::ZEBRA_MIN)
                && (near_width_reg < lect_pkg::ZEBRA_MAX);
        end
    end

    assign sts.frame_row = frame_row;
    assign sts.div_empty = div_empty;
    assign sts.out_free  = !m_valid || m_ready;

endmodule

// File: src/lane_edge_center_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lane_edge_center_tracker
// Per-row lane edge search and center tracking over a binarized frame.
// ---------------------------------------------------------------------------
// Rows enter one at a time, 31 down to 2. Each row passes through accept,
// edge search, row update, check and result load; on row 2 a bit-serial
// divide can run between check and result load to form the frame mean
// center. A finished result sits in the output register, and the next
// row is accepted while it waits. Configuration writes are taken at any time
// (cfg_ready is always high) but belong between frames.
module lane_edge_center_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic              cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [4:0]        s_row_index,
    input  logic [39:0]       s_pixels_left,
    input  logic [39:0]       s_pixels_right,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [4:0]        m_row_number,
    output logic              m_row_used,
    output logic signed [7:0] m_left_edge,
    output logic [7:0]        m_right_edge,
    output logic [6:0]        m_center,
    output logic [7:0]        m_lane_width,
    output logic [1:0]        m_edge_status,
    output logic              m_frame_done,
    output logic signed [8:0] m_steering,
    output logic              m_stop_request
);

    lect_pkg::ctrl_cmd_t cmd;
    lect_pkg::ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    lect_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lect_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_row_index    (s_row_index),
        .s_pixels_left  (s_pixels_left),
        .s_pixels_right (s_pixels_right),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_row_number   (m_row_number),
        .m_row_used     (m_row_used),
        .m_left_edge    (m_left_edge),
        .m_right_edge   (m_right_edge),
        .m_center       (m_center),
        .m_lane_width   (m_lane_width),
        .m_edge_status  (m_edge_status),
        .m_frame_done   (m_frame_done),
        .m_steering     (m_steering),
        .m_stop_request (m_stop_request)
    );

    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_row_number == lect_pkg::FAR_ROW)
        else $error("frame flag on a row other than the last");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_row_used |-> m_center == '0 && m_lane_width == '0
            && m_edge_status == '0)
        else $error("unused row carries edge data");

    a_center_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_center <= lect_pkg::COL_LAST)
        else $error("center out of range");

    a_frame_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_done |-> m_steering == '0 && !m_stop_request)
        else $error("frame fields set on an inner row");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the lane edge and center tracker.
// ---------------------------------------------------------------------------
// Feeds whole frames (rows 31 down to 2) with random lane-like pixel rows,
// plus noise rows and out-of-range indexes. A built-in row predictor forms
// the expected beat for every accepted row, and a scoreboard checks every
// result beat field by field. Configuration changes between frames.
module tb;

    typedef struct packed {
        logic [4:0]        row;
        logic              used;
        logic signed [7:0] left;
        logic [7:0]        right;
        logic [6:0]        center;
        logic [7:0]        width;
        logic [1:0]        status;
        logic              done;
        logic signed [8:0] steer;
        logic              stop;
    } row_result_t;

    int fail_count = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    class lane_scoreboard;
        bit ring_right, ring_exit, ring_inside, ring_entered, stop_detect;
        int base_col, recent[2], lhist[2], rhist[2], prev_c, bottom_c;
        int csum, stop_row, ended, near_w;
        int lstore[32], rstore[32];
        row_result_t pending[$];

        function void clear();
            {ring_right, ring_exit, ring_inside, ring_entered, stop_detect} = '0;
            base_col = 40; recent[0] = 40; recent[1] = 40;
            lhist = '{0, 0}; rhist = '{0, 0};
            prev_c = 0; bottom_c = 0; csum = 0; stop_row = 2; ended = 0; near_w = 0;
            foreach (lstore[i]) begin lstore[i] = 0; rstore[i] = 0; end
            pending.delete();
        endfunction

        function void write_reg(logic [2:0] idx, bit v);
            case (idx)
                lect_pkg::CFG_RING_RIGHT:   ring_right = v;
                lect_pkg::CFG_RING_EXIT:    ring_exit = v;
                lect_pkg::CFG_RING_INSIDE:  ring_inside = v;
                lect_pkg::CFG_RING_ENTERED: ring_entered = v;
                lect_pkg::CFG_STOP_DETECT:  stop_detect = v;
                default: ;
            endcase
        endfunction

        static function int s8(int v);
            return int'($signed(8'(v)));
        endfunction

        static function int w8(int v);
            return v & 255;
        endfunction

        static function bit black(logic [79:0] px, int c);
            return (c >= 0 && c < 80) ? px[c] : 1'b0;
        endfunction

        static function int seek_left(logic [79:0] px, int from);
            for (int j = from; j >= 0; j--) if (black(px, j)) return j;
            return -1;
        endfunction

        static function int seek_right(logic [79:0] px, int from);
            for (int j = (from < 0 ? 0 : from); j <= 79; j++) if (black(px, j)) return j;
            return -1;
        endfunction

        function void push_edges(int row, int l, int r);
            lhist[1] = lhist[0]; lhist[0] = l;
            rhist[1] = rhist[0]; rhist[0] = r;
            lstore[row] = l; rstore[row] = r;
        endfunction

        function void note_row(logic [4:0] row, logic [79:0] px);
            row_result_t e;
            int l, r, m, lf, rf, st, cnt, sv, pc, l1, l2, r1, r2;
            bit used;
            e = '0; e.row = row;
            l = 0; r = 0; m = 0; st = 0; used = 0;
            if (row >= 2) begin
                if (row > 29) begin
                    lf = seek_left(px, base_col);
                    rf = seek_right(px, base_col);
                    if (lf >= 0 && rf >= 0) begin l = lf; r = rf; m = (l + r) / 2; end
                    else if (lf < 0 && rf < 0) begin m = base_col; l = 0; r = 79; end
                    else if (lf < 0) begin r = rf; l = 0; m = r / 2; end
                    else begin l = lf; r = 79; m = (l + r) / 2; end
                    st = (lf < 0 ? 1 : 0) | (rf < 0 ? 2 : 0);
                    l = s8(l); r = w8(r);
                    if (row == 30) begin
                        m = (m + bottom_c) / 2;
                        base_col = m & 127; prev_c = base_col;
                        csum = 0; ended = 0; stop_row = 2;
                    end else bottom_c = m & 127;
                    push_edges(row, l, r);
                    used = 1;
                end else if (!ended) begin
                    pc = prev_c;
                    if (black(px, pc)) begin
                        stop_row = (row + 1) & 31; ended = 1;
                    end else begin
                        l1 = lhist[0]; l2 = lhist[1]; r1 = rhist[0]; r2 = rhist[1];
                        lf = seek_left(px, pc); rf = seek_right(px, pc);
                        l = lf >= 0 ? s8(lf) : lstore[row];
                        r = rf >= 0 ? w8(rf) : rstore[row];
                        st = (lf < 0 ? 1 : 0) | (rf < 0 ? 2 : 0);
                        if (lf < 0 && rf < 0) begin
                            if (!ring_right) begin
                                l = s8(2 * l1 - l2); r = w8(2 * r1 - r2);
                            end else if (!ring_inside) begin
                                r = w8(r1 + 1); l = s8(l1 + 1);
                            end
                        end else if (lf < 0) begin
                            if (r > r1) begin l = s8(l1 + r1 - r); r = w8(2 * r1 - r); end
                            else l = s8(l1 + r - r1);
                        end else if (rf < 0) begin
                            if (l < l1) begin r = w8(r1 + l1 - l); l = s8(2 * l1 - l); end
                            else r = w8(r1 + l - l1);
                        end
                        if (ring_exit && ring_right) r = w8(l + 40);
                        if (r - r1 > 10) r = w8(r1 + 10);
                        else if (r - r1 < -10) r = w8(r1 - 10);
                        if (l - l1 > 10) l = s8(l1 + 10);
                        else if (l - l1 < -10) l = s8(l1 - 10);
                        m = s8((l + r) / 2);
                        if (m - pc > 3) m = pc + 2;
                        if (m - pc < -3) m = pc - 2;
                        if (m < 0) m = 0;
                        else if (m > 79) m = 79;
                        csum = (csum + m) & 12'hfff;
                        if (row == 29) near_w = w8(r - l);
                        if (row <= 2) stop_row = 2;
                        prev_c = m;
                        push_edges(row, l, r);
                        used = 1;
                    end
                end
            end
            if (used) begin
                e.used = 1; e.left = 8'(l); e.right = 8'(r); e.center = 7'(m);
                e.width = 8'(r - l); e.status = 2'(st);
            end
            if (row == 2) begin
                cnt = 29 - stop_row + 1;
                if (csum != 0 && cnt > 0) begin
                    sv = csum / cnt;
                    recent[1] = recent[0]; recent[0] = s8(sv);
                end else sv = 2 * recent[0] - recent[1];
                e.done = 1; e.steer = 9'(sv);
                e.stop = stop_detect && !ring_entered && near_w > 3 && near_w < 20;
            end
            pending.push_back(e);
        endfunction

        task check_row(row_result_t g);
            row_result_t w;
            if (pending.size() == 0) begin
                report("unexpected beat, row", g.row, -1);
                return;
            end
            w = pending.pop_front();
            if (g.row != w.row) report("row_number", g.row, w.row);
            if (g.used != w.used) report("row_used", g.used, w.used);
            if (g.left != w.left) report("left_edge", g.left, w.left);
            if (g.right != w.right) report("right_edge", g.right, w.right);
            if (g.center != w.center) report("center", g.center, w.center);
            if (g.width != w.width) report("lane_width", g.width, w.width);
            if (g.status != w.status) report("edge_status", g.status, w.status);
            if (g.done != w.done) report("frame_done", g.done, w.done);
            if (g.steer != w.steer) report("steering", g.steer, w.steer);
            if (g.stop != w.stop) report("stop_request", g.stop, w.stop);
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic cfg_valid = 0, cfg_ready, cfg_data = 0;
    logic [2:0] cfg_index = lect_pkg::CFG_RING_RIGHT;
    logic s_valid = 0, s_ready;
    logic [4:0] s_row_index = '0;
    logic [39:0] s_pixels_left = '0, s_pixels_right = '0;
    logic m_valid, m_ready = 0;
    logic [4:0] m_row_number;
    logic m_row_used, m_frame_done, m_stop_request;
    logic signed [7:0] m_left_edge;
    logic [7:0] m_right_edge, m_lane_width;
    logic [6:0] m_center;
    logic [1:0] m_edge_status;
    logic signed [8:0] m_steering;

    lane_edge_center_tracker dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    lane_scoreboard sb = new();
    int rows_sent = 0;
    int hold_off = 0;
    bit sink_on = 0;

    // result side: random stalls, one long stall early on
    initial begin
        int wait_n;
        @(posedge aclk iff aresetn);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (!sink_on && rows_sent > 40 && rows_sent < 60) begin
                sink_on = 1;
                wait_n = 300;
            end
            if (wait_n > 0) begin
                m_ready <= 0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk iff m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_row({m_row_number, m_row_used, m_left_edge, m_right_edge, m_center,
                          m_lane_width, m_edge_status, m_frame_done, m_steering,
                          m_stop_request});
        end
    end

    task automatic send_row(input logic [4:0] row, input logic [79:0] px, input bit burst);
        s_valid <= 1;
        s_row_index <= row;
        s_pixels_left <= px[39:0];
        s_pixels_right <= px[79:40];
        @(posedge aclk iff s_ready);
        sb.note_row(row, px);
        rows_sent++;
        s_valid <= 0;
        @(posedge aclk);
        if (!burst) repeat ($urandom_range(0, 11)) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input bit v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk iff cfg_ready);
        sb.write_reg(idx, v);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // lane-like row: black at and left of a, black at and right of b, with random specks
    function automatic logic [79:0] lane_row(int a, int b, int noise);
        logic [79:0] px;
        px = '0;
        for (int c = 0; c < 80; c++) begin
            if (c <= a || c >= b) px[c] = 1;
            if ($urandom_range(0, 99) < noise) px[c] = ~px[c];
        end
        return px;
    endfunction

    function automatic logic [79:0] rand_px();
        return {$urandom(), $urandom(), 16'($urandom())};
    endfunction

    task automatic send_frame(input int kind, input bit burst);
        int a, b, stop_at;
        logic [79:0] px;
        a = $urandom_range(0, 45);
        b = a + $urandom_range(4, 40);
        stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 29) : -1;
        for (int row = 31; row >= 2; row--) begin
            case (kind)
                0: px = lane_row(a, b, $urandom_range(0, 3));
                1: px = rand_px();
                2: px = ($urandom_range(0, 1)) ? '0 : lane_row(a, b, 0);
                default: px = ($urandom_range(0, 1)) ? '1 : lane_row(a, b, 2);
            endcase
            if (row == stop_at) px = '1;
            send_row(5'(row), px, burst);
            a = a + $urandom_range(0, 6) - 3;
            b = b + $urandom_range(0, 6) - 3;
            if (a < -1) a = -1;
            if (b > 80) b = 80;
            if (b < a + 2) b = a + 2;
        end
    endtask

    initial begin
        sb.clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: field extremes, out-of-range rows, empty and full rows
        send_row(5'd0, '0, 0);
        send_row(5'd1, '1, 0);
        send_row(5'd31, '0, 0);
        send_row(5'd30, '1, 0);
        send_row(5'd29, {40'h0, 40'h1}, 0);
        send_row(5'd28, {40'h80_0000_0000, 40'h0}, 0);
        send_row(5'd2, '0, 0);
        send_row(5'd2, '0, 0);
        send_row(5'd17, 80'h5555_5555_5555_5555_5555, 0);
        drain();
        for (int f = 0; f < 58; f++) begin
            if (f % 6 == 0) begin
                for (int i = 0; i < 5; i++) write_reg(3'(i), $urandom_range(0, 1));
                if (f == 0) for (int i = 0; i < 5; i++) write_reg(3'(i), 1'b1);
                if (f == 6) for (int i = 0; i < 5; i++) write_reg(3'(i), 1'b0);
            end
            if (f % 9 == 4) send_row(5'($urandom_range(0, 31)), rand_px(), 0);
            send_frame((f % 5 == 4) ? 1 : (f % 5 == 3) ? 2 + (f & 1) : 0,
                       f == 1 || f % 7 == 5);
            if (f % 6 == 5) drain();
        end
        drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
